// ===== hdl/ichk_pkg.sv =====
// Package: shared types, register indexes, mode codes and the end-around-carry adder.
`timescale 1ns / 1ps

package ichk_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] CSR_MODE        = 3'd0;
   localparam logic [2:0] CSR_INITIAL_SUM = 3'd1;
   localparam logic [2:0] CSR_SOURCE_ADDR = 3'd2;
   localparam logic [2:0] CSR_DEST_ADDR   = 3'd3;
   localparam logic [2:0] CSR_PROTOCOL    = 3'd4;
   localparam logic [2:0] CSR_SWAP_RESULT = 3'd5;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Mode codes
   localparam logic [1:0] MODE_PARTIAL    = 2'd0;
   localparam logic [1:0] MODE_COMPLEMENT = 2'd1;
   localparam logic [1:0] MODE_PSEUDO     = 2'd2;

   localparam logic [1:0]  MODE_RESET  = MODE_COMPLEMENT;
   localparam logic [15:0] WORD_ONES   = 16'hFFFF;
   localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] checksum;
      logic        length_overflow;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] initial_sum;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [7:0]  protocol_number;
      logic        swap_result;
   } csr_type;

   // Per-packet result controls carried down the finishing pipeline
   typedef struct packed {
      logic complement;
      logic swap;
      logic overflow;
   } fin_ctl_type;

   // Packet transaction handed from the byte accumulator to the finisher
   typedef struct packed {
      logic [15:0] data_sum;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [7:0]  protocol_number;
      logic [15:0] byte_count;
      fin_ctl_type ctl;
   } fin_type;

   // Ones' complement add with the carry folded back in
   function automatic logic [15:0] add_folded(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// ===== hdl/internet_checksum_pseudo_header_top.sv =====
// Top level: Internet checksum over a byte stream with optional IPv4 pseudo header.
// Throughput: one byte per clock with no gap between packets, unless the result path stalls.
// After the last byte is accepted, the result passes the input register, capture stage,
//   two pseudo header fold stages and result register; a stalled output holds it back.
// Only the byte marked last produces a result transaction.
// Reset (synchronous): clears valid flags and packet state; mode returns to 1, other regs to 0.
`timescale 1ns / 1ps

module internet_checksum_pseudo_header_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ichk_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ichk_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [ichk_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ichk_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   ichk_pkg::csr_type cfg;
   ichk_pkg::fin_type fin_data;
   logic              fin_valid;
   logic              fin_ready;

   ichk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ichk_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_data  (fin_data)
   );

   ichk_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_data  (fin_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/ichk_csr.sv =====
// Configuration registers written through the plain write port.
`timescale 1ns / 1ps

module ichk_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [ichk_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ichk_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output ichk_pkg::csr_type                     cfg
);

   ichk_pkg::csr_type cfg_ff;
   ichk_pkg::csr_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ichk_pkg::CSR_MODE:        cfg_in.mode                = csr_wdata[1:0];
            ichk_pkg::CSR_INITIAL_SUM: cfg_in.initial_sum         = csr_wdata[15:0];
            ichk_pkg::CSR_SOURCE_ADDR: cfg_in.source_address      = csr_wdata;
            ichk_pkg::CSR_DEST_ADDR:   cfg_in.destination_address = csr_wdata;
            ichk_pkg::CSR_PROTOCOL:    cfg_in.protocol_number     = csr_wdata[7:0];
            ichk_pkg::CSR_SWAP_RESULT: cfg_in.swap_result         = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode                <= ichk_pkg::MODE_RESET;
         cfg_ff.initial_sum         <= '0;
         cfg_ff.source_address      <= '0;
         cfg_ff.destination_address <= '0;
         cfg_ff.protocol_number     <= '0;
         cfg_ff.swap_result         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/ichk_accum.sv =====
// Input register, per-byte word pairing and accumulation, packet capture stage.
`timescale 1ns / 1ps

module ichk_accum (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ichk_pkg::req_type   req_data,
   input  ichk_pkg::csr_type   cfg,
   output logic                fin_valid,
   input  logic                fin_ready,
   output ichk_pkg::fin_type   fin_data
);

   logic              in_valid_ff, in_valid_in;
   ichk_pkg::req_type in_data_ff, in_data_in;

   logic [15:0] acc_ff, acc_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic        sat_ff, sat_in;

   logic              fin_valid_ff, fin_valid_in;
   ichk_pkg::fin_type fin_data_ff, fin_data_in;

   logic        s1_ready;
   logic        s0_go;
   logic        s0_last_go;
   logic        at_limit;
   logic [15:0] base_sum;
   logic [15:0] pair_word;
   logic [15:0] pair_sum;
   logic [15:0] count_next;
   logic        sat_next;
   logic        pseudo_on;

   // Handshake across the input register
   assign s1_ready   = !fin_valid_ff || fin_ready;
   assign s0_go      = in_valid_ff && (!in_data_ff.last_byte || s1_ready);
   assign s0_last_go = s0_go && in_data_ff.last_byte;
   assign req_stall  = in_valid_ff && !s0_go;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (s0_go) begin
         in_valid_in = 1'b0;
      end
   end

   // Pair bytes into words and add them; first byte starts from the initial sum
   assign at_limit   = (count_ff == ichk_pkg::COUNT_LIMIT);
   assign base_sum   = (count_ff == 16'd0) ? cfg.initial_sum : acc_ff;
   assign pair_word  = held_valid_ff ? {held_ff, in_data_ff.data_byte}
                                     : {in_data_ff.data_byte, 8'h00};
   assign pair_sum   = ichk_pkg::add_folded(base_sum, pair_word);
   assign count_next = at_limit ? count_ff : count_ff + 16'd1;
   assign sat_next   = sat_ff || at_limit;
   assign pseudo_on  = (cfg.mode == ichk_pkg::MODE_PSEUDO);

   always_comb begin
      acc_in        = acc_ff;
      count_in      = count_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      sat_in        = sat_ff;
      if (s0_go) begin
         if (in_data_ff.last_byte) begin
            // Packet done: clear for the next one
            acc_in        = '0;
            count_in      = '0;
            held_in       = '0;
            held_valid_in = 1'b0;
            sat_in        = 1'b0;
         end else begin
            count_in = count_next;
            sat_in   = sat_next;
            if (held_valid_ff) begin
               acc_in        = pair_sum;
               held_in       = '0;
               held_valid_in = 1'b0;
            end else begin
               acc_in        = base_sum;
               held_in       = in_data_ff.data_byte;
               held_valid_in = 1'b1;
            end
         end
      end
   end

   // Capture the packet transaction; pseudo header terms are zero outside pseudo mode
   always_comb begin
      fin_valid_in = fin_valid_ff;
      fin_data_in  = fin_data_ff;
      if (s1_ready) begin
         fin_valid_in = s0_last_go;
         if (s0_last_go) begin
            fin_data_in.data_sum            = pair_sum;
            fin_data_in.source_address      = pseudo_on ? cfg.source_address : '0;
            fin_data_in.destination_address = pseudo_on ? cfg.destination_address : '0;
            fin_data_in.protocol_number     = pseudo_on ? cfg.protocol_number : '0;
            fin_data_in.byte_count          = pseudo_on ? count_next : '0;
            fin_data_in.ctl.complement      = (cfg.mode != ichk_pkg::MODE_PARTIAL);
            fin_data_in.ctl.swap            = cfg.swap_result;
            fin_data_in.ctl.overflow        = sat_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         acc_ff        <= '0;
         count_ff      <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         sat_ff        <= 1'b0;
         fin_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         acc_ff        <= acc_in;
         count_ff      <= count_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         sat_ff        <= sat_in;
         fin_valid_ff  <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      fin_data_ff <= fin_data_in;
   end

   assign fin_valid = fin_valid_ff;
   assign fin_data  = fin_data_ff;

`ifndef SYNTHESIS
   // Before saturation, a held byte waits exactly when the byte count is odd
   assert property (@(posedge clock) disable iff (reset)
      !sat_ff |-> (held_valid_ff == count_ff[0]))
      else $error("held byte flag out of step with byte count");

   // Saturation only ever happens at the count limit
   assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (count_ff == ichk_pkg::COUNT_LIMIT))
      else $error("saturated flag set below count limit");

   // Closing a packet leaves clean per-packet state
   assert property (@(posedge clock) disable iff (reset)
      s0_last_go |=> (count_ff == 16'd0) && !held_valid_ff && !sat_ff && (acc_ff == 16'd0))
      else $error("packet state not cleared after last byte");

   // A finished packet is never dropped while the capture stage is full
   assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !fin_ready) |=> fin_valid_ff)
      else $error("capture stage lost a packet transaction");
`endif

endmodule

// ===== hdl/ichk_finish.sv =====
// Pseudo header fold, complement, byte swap and result register.
`timescale 1ns / 1ps

module ichk_finish (
   input  logic                clock,
   input  logic                reset,
   input  logic                fin_valid,
   output logic                fin_ready,
   input  ichk_pkg::fin_type   fin_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ichk_pkg::rsp_type   rsp_data
);

   logic                  s2_valid_ff, s2_valid_in;
   logic [15:0]           p_src_ff, p_src_in;
   logic [15:0]           p_dst_ff, p_dst_in;
   logic [15:0]           p_len_ff, p_len_in;
   logic [15:0]           d_sum_ff, d_sum_in;
   ichk_pkg::fin_ctl_type s2_ctl_ff, s2_ctl_in;

   logic                  s3_valid_ff, s3_valid_in;
   logic [15:0]           q_ff, q_in;
   logic [15:0]           r_ff, r_in;
   ichk_pkg::fin_ctl_type s3_ctl_ff, s3_ctl_in;

   logic              rsp_valid_ff, rsp_valid_in;
   ichk_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        out_ready;
   logic        s3_ready;
   logic        s2_ready;
   logic [15:0] total;
   logic [15:0] folded;

   // Per-stage ready; a bubble never blocks
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign fin_ready = s2_ready;

   // First level: fold address halves and protocol with length
   always_comb begin
      s2_valid_in = s2_valid_ff;
      p_src_in    = p_src_ff;
      p_dst_in    = p_dst_ff;
      p_len_in    = p_len_ff;
      d_sum_in    = d_sum_ff;
      s2_ctl_in   = s2_ctl_ff;
      if (s2_ready) begin
         s2_valid_in = fin_valid;
         p_src_in    = ichk_pkg::add_folded(fin_data.source_address[31:16],
                                            fin_data.source_address[15:0]);
         p_dst_in    = ichk_pkg::add_folded(fin_data.destination_address[31:16],
                                            fin_data.destination_address[15:0]);
         p_len_in    = ichk_pkg::add_folded({8'd0, fin_data.protocol_number},
                                            fin_data.byte_count);
         d_sum_in    = fin_data.data_sum;
         s2_ctl_in   = fin_data.ctl;
      end
   end

   // Second level: pair the partial sums
   always_comb begin
      s3_valid_in = s3_valid_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      s3_ctl_in   = s3_ctl_ff;
      if (s3_ready) begin
         s3_valid_in = s2_valid_ff;
         q_in        = ichk_pkg::add_folded(p_src_ff, p_dst_ff);
         r_in        = ichk_pkg::add_folded(p_len_ff, d_sum_ff);
         s3_ctl_in   = s2_ctl_ff;
      end
   end

   // Last level: final add, optional complement and optional byte swap
   assign total  = ichk_pkg::add_folded(q_ff, r_ff);
   assign folded = s3_ctl_ff.complement ? (total ^ ichk_pkg::WORD_ONES) : total;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in                = s3_valid_ff;
         rsp_data_in.checksum        = s3_ctl_ff.swap ? {folded[7:0], folded[15:8]} : folded;
         rsp_data_in.length_overflow = s3_ctl_ff.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_src_ff    <= p_src_in;
      p_dst_ff    <= p_dst_in;
      p_len_ff    <= p_len_in;
      d_sum_ff    <= d_sum_in;
      s2_ctl_ff   <= s2_ctl_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      s3_ctl_ff   <= s3_ctl_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
